>>> rtl/core/ccm_is_pkg.sv
// Shared types and constants for the color correction matrix block.
// Holds fixed-point formats, color space constant tables and action codes.
// No dependencies; imported by the divider and the top level.
package ccm_is_pkg;

   // Fixed-point formats.
   localparam int FRAC_BITS  = 12;
   localparam int CONST_FRAC = 16;
   localparam int MIX_FRAC   = 24;
   localparam int A_SHIFT    = 2 * CONST_FRAC + FRAC_BITS - MIX_FRAC;

   localparam int TEMP_W  = 16;
   localparam int GAIN_W  = 16;
   localparam int COEF_W  = 20;
   localparam int OUT_W   = 16;
   localparam int SAT_W   = 21;
   localparam int OPA_W   = 22;
   localparam int OPB_W   = 18;
   localparam int PROD_W  = OPA_W + OPB_W;
   localparam int ACC_W   = 64;
   localparam int A_W     = 34;
   localparam int CHUNK_W = 17;

   // Divider: quotient magnitude always fits in DIV_STEPS bits.
   localparam int DIV_STEPS = 20;
   localparam int DEN_W     = 16;
   localparam int QUOT_W    = DIV_STEPS + 1;
   localparam int CNT_W     = 5;

   localparam int DEF_TEMP = 4000;
   localparam int DEF_LUX  = 400;

   localparam longint COEF_MAX = (longint'(79999) * (longint'(1) << FRAC_BITS)) / 10000;
   localparam longint COEF_MIN = -(longint'(8) << FRAC_BITS);

   typedef enum logic [1:0] {
      ACT_LOAD_TEMP  = 2'd0,
      ACT_LOAD_COEF  = 2'd1,
      ACT_LOAD_CURVE = 2'd2,
      ACT_COMPUTE    = 2'd3
   } action_type;

   localparam logic [1:0] CSR_USER_SAT = 2'd0;
   localparam logic [1:0] CSR_ENTRIES  = 2'd1;
   localparam logic [1:0] CSR_POINTS   = 2'd2;

   // RGB to YCbCr and back, Q.16, row-major.
   localparam longint RGB_TO_Y [9] = '{
      19595, 38470, 7471,
      -11076, -21692, 32768,
      32768, -27460, -5308
   };
   localparam longint Y_TO_RGB [9] = '{
      65536, 0, 91881,
      65536, -22610, -46793,
      65536, 116064, 0
   };

   // Luma part of the mixing matrix, already scaled by 2^FRAC_BITS.
   function automatic longint luma_const(int r, int c);
      return (Y_TO_RGB[r * 3] * RGB_TO_Y[c]) * (longint'(1) << FRAC_BITS);
   endfunction

   // Chroma part of the mixing matrix; it is multiplied by the saturation.
   function automatic longint chroma_const(int r, int c);
      return Y_TO_RGB[r * 3 + 1] * RGB_TO_Y[3 + c] + Y_TO_RGB[r * 3 + 2] * RGB_TO_Y[6 + c];
   endfunction

   localparam longint LUMA_TBL [9] = '{
      luma_const(0, 0), luma_const(0, 1), luma_const(0, 2),
      luma_const(1, 0), luma_const(1, 1), luma_const(1, 2),
      luma_const(2, 0), luma_const(2, 1), luma_const(2, 2)
   };
   localparam longint CHROMA_TBL [9] = '{
      chroma_const(0, 0), chroma_const(0, 1), chroma_const(0, 2),
      chroma_const(1, 0), chroma_const(1, 1), chroma_const(1, 2),
      chroma_const(2, 0), chroma_const(2, 1), chroma_const(2, 2)
   };

endpackage

>>> rtl/core/ccm_is_div.sv
// Iterative rounding divider, one quotient bit per cycle.
// Depends on ccm_is_pkg for the operand and quotient widths.
module ccm_is_div
   import ccm_is_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [PROD_W-1:0] num,
   input  logic        [DEN_W-1:0]  den,
   output logic                     done,
   output logic signed [QUOT_W-1:0] quot
);

   logic                 busy_ff;
   logic                 done_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [DEN_W-1:0]     rem_ff;
   logic [DEN_W-1:0]     den_ff;
   logic [DIV_STEPS-1:0] sh_ff;
   logic                 neg_ff;

   logic [PROD_W-1:0] mag;
   logic [DEN_W:0]    trial;
   logic              ge;

   // Magnitude plus half the divisor, so the truncated quotient rounds away from zero.
   always_comb begin
      if (num[PROD_W-1]) begin
         mag = ~num + PROD_W'({1'b0, den[DEN_W-1:1]}) + PROD_W'(1);
      end else begin
         mag = num + PROD_W'({1'b0, den[DEN_W-1:1]});
      end
      trial = {rem_ff, sh_ff[DIV_STEPS-1]};
      ge    = trial >= {1'b0, den_ff};
   end

   // Restoring division over the low quotient bits; the high part is known below the divisor.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= mag[DEN_W+DIV_STEPS-1:DIV_STEPS];
            sh_ff   <= mag[DIV_STEPS-1:0];
            neg_ff  <= num[PROD_W-1];
            den_ff  <= den;
         end else if (busy_ff) begin
            rem_ff <= ge ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
            sh_ff  <= {sh_ff[DIV_STEPS-2:0], ge};
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quot = neg_ff ? -$signed({1'b0, sh_ff}) : $signed({1'b0, sh_ff});

   // The partial remainder stays below the divisor while dividing.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> rem_ff < den_ff)
      else $error("divider remainder not below divisor");

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a division");

endmodule

>>> rtl/core/ccm_interpolate_saturate_top.sv
// Color correction matrix with temperature blending and lux-driven saturation.
// Depends on ccm_is_pkg and on the iterative divider ccm_is_div.
//
// Load items (entry temperature, coefficient, curve point) are written in the cycle
// they are accepted and give no result. req_ready is low while a compute item runs.
// Its duration is set by the shared 20-step divider, used once per blended
// coefficient and once for the curve gain, by a memory scan for the bracketing
// table entries, and by the single 22x18 multiplier, which forms the mixing
// matrix and the final product in 72 partial products. A temperature at or beyond
// the table ends skips the divider for the coefficient blend.
// The result is held in an output register until taken, and loads are accepted
// meanwhile. No clearing pass runs after reset.
module ccm_interpolate_saturate_top
   import ccm_is_pkg::*;
#(
   parameter int MAX_ENTRIES      = 16,
   parameter int MAX_CURVE_POINTS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_action,
   input  logic [3:0]               req_entry_index,
   input  logic [3:0]               req_coef_index,
   input  logic [15:0]              req_temperature_k,
   input  logic                     req_temperature_present,
   input  logic signed [19:0]       req_coef_value,
   input  logic [15:0]              req_lux_level,
   input  logic                     req_lux_present,
   input  logic [15:0]              req_gain_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [15:0]       rsp_m00,
   output logic signed [15:0]       rsp_m01,
   output logic signed [15:0]       rsp_m02,
   output logic signed [15:0]       rsp_m10,
   output logic signed [15:0]       rsp_m11,
   output logic signed [15:0]       rsp_m12,
   output logic signed [15:0]       rsp_m20,
   output logic signed [15:0]       rsp_m21,
   output logic signed [15:0]       rsp_m22,
   output logic [15:0]              rsp_reported_saturation,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [1:0]               csr_index,
   input  logic [15:0]              csr_wdata
);

   localparam int TW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int GW = (MAX_CURVE_POINTS > 1) ? $clog2(MAX_CURVE_POINTS) : 1;
   localparam int IW = (TW > GW) ? TW : GW;
   localparam int CW = $clog2(MAX_ENTRIES * 9);
   localparam int NW = 7;

   typedef enum logic [4:0] {
      S_IDLE, S_SFIRST, S_SLAST, S_SCHK, S_SADDR, S_SCMP, S_FOUND,
      S_CRD0, S_CRD1, S_CMUL, S_CWAIT, S_CDIV, S_CDIVW,
      S_GWAIT, S_GDIV, S_GDIVW, S_SAT, S_SATW, S_SATW2,
      S_MINIT, S_MAC, S_DR1, S_DR2, S_RND, S_OUT
   } state_type;

   // Configuration registers.
   logic [15:0] user_sat_ff;
   logic [4:0]  entries_ff;
   logic [4:0]  points_ff;

   // Table and curve storage.
   logic [TEMP_W-1:0]        temp_mem [MAX_ENTRIES];
   logic signed [COEF_W-1:0] coef_mem [MAX_ENTRIES*9];
   logic [TEMP_W-1:0]        lux_mem  [MAX_CURVE_POINTS];
   logic [GAIN_W-1:0]        gain_mem [MAX_CURVE_POINTS];
   logic [TEMP_W-1:0]        t_rd_ff;
   logic [TEMP_W-1:0]        l_rd_ff;
   logic [GAIN_W-1:0]        g_rd_ff;
   logic signed [COEF_W-1:0] c_rd_ff;

   state_type state_ff;
   logic      phase_ff;
   logic      le0_ff;
   logic      copy_ff;
   logic      stage_ff;
   logic [IW-1:0] idx_ff;
   logic [IW-1:0] sel_ff;
   logic [3:0]    k_ff;
   logic [1:0]    r_ff;
   logic [1:0]    c_ff;
   logic [2:0]    j_ff;

   logic [TEMP_W-1:0] ct_ff;
   logic [TEMP_W-1:0] lux_ff;
   logic [TEMP_W-1:0] lo_key_ff;
   logic [TEMP_W-1:0] hi_key_ff;
   logic [GAIN_W-1:0] lo_gain_ff;
   logic [GAIN_W-1:0] hi_gain_ff;
   logic [GAIN_W-1:0] g_ff;
   logic [TEMP_W-1:0] t_ff;
   logic [DEN_W-1:0]  d_ff;
   logic signed [COEF_W-1:0] c0_ff;
   logic [SAT_W-1:0]  s_ff;

   logic signed [COEF_W-1:0] m_ff   [9];
   logic signed [A_W-1:0]    a_ff   [9];
   logic signed [OUT_W-1:0]  res_ff [9];
   logic signed [OUT_W-1:0]  out_ff [9];
   logic [15:0]              out_sat_ff;
   logic                     rsp_valid_ff;

   // Shared multiplier and accumulator.
   logic signed [OPA_W-1:0]  opa_ff;
   logic signed [OPB_W-1:0]  opb_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic iss_v1_ff, iss_v2_ff, iss_h1_ff, iss_h2_ff;

   logic req_acc;
   logic load_t, load_c, load_g;
   logic [NW-1:0] n_eff, p_eff, lim;
   logic [IW-1:0] lim_m1;
   logic [TEMP_W-1:0] key, rd_key;
   logic [IW-1:0] sel_lo;
   logic [CW-1:0] coef_wr_addr, coef_rd_addr;
   logic [COEF_W:0] cdiff;
   logic [GAIN_W:0] gdiff;
   logic [3:0] rc_idx, m_idx, a_idx;
   logic [1:0] kk;
   logic signed [ACC_W-1:0] chroma, aval;
   logic signed [OPA_W-1:0] mac_opa;
   logic signed [OPB_W-1:0] mac_opb;
   logic signed [ACC_W-1:0] prod_ext, addend, rnd_sum, rounded;
   logic signed [OUT_W-1:0] clamped;
   logic div_start, div_done;
   logic signed [QUOT_W-1:0] quot;
   logic [COEF_W:0] msum;
   logic [QUOT_W-1:0] gsum;

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign req_acc   = req_valid && req_ready;

   // Load decode; loads past the table size are dropped.
   always_comb begin
      load_t = req_acc && (req_action == ACT_LOAD_TEMP) && (int'(req_entry_index) < MAX_ENTRIES);
      load_c = req_acc && (req_action == ACT_LOAD_COEF) &&
               (int'(req_entry_index) < MAX_ENTRIES) && (req_coef_index < 4'd9);
      load_g = req_acc && (req_action == ACT_LOAD_CURVE) &&
               (int'(req_entry_index) < MAX_CURVE_POINTS);
      coef_wr_addr = CW'(int'(req_entry_index) * 9 + int'(req_coef_index));
   end

   // Effective counts and search keys.
   always_comb begin
      if (entries_ff == 5'd0) begin
         n_eff = NW'(1);
      end else if (int'(entries_ff) > MAX_ENTRIES) begin
         n_eff = NW'(MAX_ENTRIES);
      end else begin
         n_eff = NW'(entries_ff);
      end
      if (int'(points_ff) > MAX_CURVE_POINTS) begin
         p_eff = NW'(MAX_CURVE_POINTS);
      end else begin
         p_eff = NW'(points_ff);
      end
      lim    = phase_ff ? p_eff : n_eff;
      lim_m1 = IW'(lim - NW'(1));
      key    = phase_ff ? lux_ff : ct_ff;
      rd_key = phase_ff ? l_rd_ff : t_rd_ff;
      sel_lo = copy_ff ? sel_ff : sel_ff - IW'(1);
      coef_rd_addr = (state_ff == S_CRD0) ? CW'(int'(sel_lo) * 9 + int'(k_ff))
                                          : CW'(int'(sel_ff) * 9 + int'(k_ff));
      cdiff = {c_rd_ff[COEF_W-1], c_rd_ff} - {c0_ff[COEF_W-1], c0_ff};
      gdiff = {1'b0, hi_gain_ff} - {1'b0, lo_gain_ff};
      msum  = {c0_ff[COEF_W-1], c0_ff} + quot;
      gsum  = QUOT_W'(lo_gain_ff) + quot;
   end

   // Memories: written by load items, read with a registered port.
   always_ff @(posedge clock) begin
      if (load_t) begin
         temp_mem[TW'(req_entry_index)] <= req_temperature_k;
      end
      if (load_c) begin
         coef_mem[coef_wr_addr] <= req_coef_value;
      end
      if (load_g) begin
         lux_mem[GW'(req_entry_index)]  <= req_lux_level;
         gain_mem[GW'(req_entry_index)] <= req_gain_value;
      end
      t_rd_ff <= temp_mem[idx_ff[TW-1:0]];
      l_rd_ff <= lux_mem[idx_ff[GW-1:0]];
      g_rd_ff <= gain_mem[idx_ff[GW-1:0]];
      c_rd_ff <= coef_mem[coef_rd_addr];
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         user_sat_ff <= 16'd4096;
         entries_ff  <= 5'd1;
         points_ff   <= 5'd0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_USER_SAT: user_sat_ff <= csr_wdata;
            CSR_ENTRIES:  entries_ff  <= csr_wdata[4:0];
            CSR_POINTS:   points_ff   <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   // Operand selection for the multiply-accumulate passes.
   always_comb begin
      rc_idx = 4'(r_ff) * 4'd3 + 4'(c_ff);
      kk     = j_ff[2:1];
      m_idx  = 4'(kk) * 4'd3 + 4'(c_ff);
      a_idx  = 4'(r_ff) * 4'd3 + 4'(kk);
      chroma = CHROMA_TBL[rc_idx];
      aval   = ACC_W'(a_ff[a_idx]);
      if (!stage_ff) begin
         mac_opa = $signed({1'b0, s_ff});
         mac_opb = j_ff[0] ? OPB_W'(chroma >>> CHUNK_W) : $signed({1'b0, chroma[CHUNK_W-1:0]});
      end else begin
         mac_opa = OPA_W'(m_ff[m_idx]);
         mac_opb = j_ff[0] ? OPB_W'(aval >>> CHUNK_W) : $signed({1'b0, aval[CHUNK_W-1:0]});
      end
      prod_ext = ACC_W'(prod_ff);
      addend   = iss_h2_ff ? (prod_ext <<< CHUNK_W) : prod_ext;
   end

   // Rounding to nearest with ties away from zero, then the output clamp.
   always_comb begin
      if (stage_ff) begin
         rnd_sum = acc_ff + (ACC_W'(1) <<< (MIX_FRAC - 1)) - ACC_W'(acc_ff[ACC_W-1]);
         rounded = rnd_sum >>> MIX_FRAC;
      end else begin
         rnd_sum = acc_ff + (ACC_W'(1) <<< (A_SHIFT - 1)) - ACC_W'(acc_ff[ACC_W-1]);
         rounded = rnd_sum >>> A_SHIFT;
      end
      if (rounded > ACC_W'(COEF_MAX)) begin
         clamped = OUT_W'(COEF_MAX);
      end else if (rounded < ACC_W'(COEF_MIN)) begin
         clamped = OUT_W'(COEF_MIN);
      end else begin
         clamped = rounded[OUT_W-1:0];
      end
   end

   // Multiplier stage: one product per cycle from the operand registers.
   always_ff @(posedge clock) begin
      prod_ff <= opa_ff * opb_ff;
   end

   assign div_start = (state_ff == S_CDIV) || (state_ff == S_GDIV);

   ccm_is_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (prod_ff),
      .den   (d_ff),
      .done  (div_done),
      .quot  (quot)
   );

   // Sequencer: search, blend, curve gain, saturation, matrix products.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         iss_v1_ff    <= 1'b0;
         iss_v2_ff    <= 1'b0;
      end else begin
         iss_v1_ff <= (state_ff == S_MAC);
         iss_v2_ff <= iss_v1_ff;
         iss_h1_ff <= j_ff[0];
         iss_h2_ff <= iss_h1_ff;
         if (iss_v2_ff) begin
            acc_ff <= acc_ff + addend;
         end
         // The output state reloads the result register itself.
         if (rsp_valid_ff && rsp_ready && (state_ff != S_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_acc && (req_action == ACT_COMPUTE)) begin
                  ct_ff    <= req_temperature_present ? req_temperature_k : TEMP_W'(DEF_TEMP);
                  lux_ff   <= req_lux_present ? req_lux_level : TEMP_W'(DEF_LUX);
                  phase_ff <= 1'b0;
                  idx_ff   <= '0;
                  state_ff <= S_SFIRST;
               end
            end
            S_SFIRST: begin
               idx_ff   <= lim_m1;
               state_ff <= S_SLAST;
            end
            S_SLAST: begin
               lo_key_ff  <= rd_key;
               lo_gain_ff <= g_rd_ff;
               le0_ff     <= (key <= rd_key);
               state_ff   <= S_SCHK;
            end
            S_SCHK: begin
               if (le0_ff) begin
                  copy_ff    <= 1'b1;
                  sel_ff     <= '0;
                  hi_key_ff  <= lo_key_ff;
                  hi_gain_ff <= lo_gain_ff;
                  state_ff   <= S_FOUND;
               end else if (key >= rd_key) begin
                  copy_ff    <= 1'b1;
                  sel_ff     <= lim_m1;
                  hi_key_ff  <= rd_key;
                  hi_gain_ff <= g_rd_ff;
                  state_ff   <= S_FOUND;
               end else begin
                  idx_ff   <= IW'(1);
                  state_ff <= S_SADDR;
               end
            end
            S_SADDR: begin
               state_ff <= S_SCMP;
            end
            S_SCMP: begin
               if ((idx_ff == lim_m1) || (key <= rd_key)) begin
                  copy_ff    <= 1'b0;
                  sel_ff     <= idx_ff;
                  hi_key_ff  <= rd_key;
                  hi_gain_ff <= g_rd_ff;
                  state_ff   <= S_FOUND;
               end else begin
                  lo_key_ff  <= rd_key;
                  lo_gain_ff <= g_rd_ff;
                  idx_ff     <= idx_ff + IW'(1);
                  state_ff   <= S_SADDR;
               end
            end
            S_FOUND: begin
               t_ff <= key - lo_key_ff;
               d_ff <= hi_key_ff - lo_key_ff;
               if (!phase_ff) begin
                  k_ff     <= '0;
                  state_ff <= S_CRD0;
               end else if (copy_ff) begin
                  g_ff     <= hi_gain_ff;
                  state_ff <= S_SAT;
               end else begin
                  opa_ff   <= OPA_W'($signed(gdiff));
                  opb_ff   <= $signed({2'b00, key - lo_key_ff});
                  state_ff <= S_GWAIT;
               end
            end
            S_CRD0: begin
               state_ff <= S_CRD1;
            end
            S_CRD1: begin
               c0_ff    <= c_rd_ff;
               state_ff <= S_CMUL;
            end
            S_CMUL, S_CDIVW: begin
               if ((state_ff == S_CMUL) && !copy_ff) begin
                  opa_ff   <= OPA_W'($signed(cdiff));
                  opb_ff   <= $signed({2'b00, t_ff});
                  state_ff <= S_CWAIT;
               end else if ((state_ff == S_CMUL) || div_done) begin
                  m_ff[k_ff] <= copy_ff ? c0_ff : msum[COEF_W-1:0];
                  if (k_ff == 4'd8) begin
                     if (p_eff == NW'(0)) begin
                        s_ff     <= SAT_W'(user_sat_ff);
                        r_ff     <= '0;
                        c_ff     <= '0;
                        stage_ff <= 1'b0;
                        state_ff <= S_MINIT;
                     end else begin
                        phase_ff <= 1'b1;
                        idx_ff   <= '0;
                        state_ff <= S_SFIRST;
                     end
                  end else begin
                     k_ff     <= k_ff + 4'd1;
                     state_ff <= S_CRD0;
                  end
               end
            end
            S_CWAIT: begin
               state_ff <= S_CDIV;
            end
            S_CDIV: begin
               state_ff <= S_CDIVW;
            end
            S_GWAIT: begin
               state_ff <= S_GDIV;
            end
            S_GDIV: begin
               state_ff <= S_GDIVW;
            end
            S_GDIVW: begin
               if (div_done) begin
                  g_ff     <= gsum[GAIN_W-1:0];
                  state_ff <= S_SAT;
               end
            end
            S_SAT: begin
               opa_ff   <= OPA_W'($signed({1'b0, user_sat_ff}));
               opb_ff   <= $signed({2'b00, g_ff});
               state_ff <= S_SATW;
            end
            S_SATW: begin
               state_ff <= S_SATW2;
            end
            S_SATW2: begin
               s_ff     <= SAT_W'((prod_ff + PROD_W'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS);
               r_ff     <= '0;
               c_ff     <= '0;
               stage_ff <= 1'b0;
               state_ff <= S_MINIT;
            end
            S_MINIT: begin
               acc_ff   <= stage_ff ? '0 : ACC_W'(LUMA_TBL[rc_idx]);
               j_ff     <= '0;
               state_ff <= S_MAC;
            end
            S_MAC: begin
               opa_ff <= mac_opa;
               opb_ff <= mac_opb;
               if (j_ff == (stage_ff ? 3'd5 : 3'd1)) begin
                  state_ff <= S_DR1;
               end else begin
                  j_ff <= j_ff + 3'd1;
               end
            end
            S_DR1: begin
               state_ff <= S_DR2;
            end
            S_DR2: begin
               state_ff <= S_RND;
            end
            S_RND: begin
               if (stage_ff) begin
                  res_ff[rc_idx] <= clamped;
               end else begin
                  a_ff[rc_idx] <= rounded[A_W-1:0];
               end
               state_ff <= S_MINIT;
               if (c_ff == 2'd2) begin
                  c_ff <= '0;
                  if (r_ff == 2'd2) begin
                     r_ff <= '0;
                     if (stage_ff) begin
                        state_ff <= S_OUT;
                     end else begin
                        stage_ff <= 1'b1;
                     end
                  end else begin
                     r_ff <= r_ff + 2'd1;
                  end
               end else begin
                  c_ff <= c_ff + 2'd1;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  out_ff       <= res_ff;
                  out_sat_ff   <= user_sat_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_m00                 = out_ff[0];
   assign rsp_m01                 = out_ff[1];
   assign rsp_m02                 = out_ff[2];
   assign rsp_m10                 = out_ff[3];
   assign rsp_m11                 = out_ff[4];
   assign rsp_m12                 = out_ff[5];
   assign rsp_m20                 = out_ff[6];
   assign rsp_m21                 = out_ff[7];
   assign rsp_m22                 = out_ff[8];
   assign rsp_reported_saturation = out_sat_ff;

   // The scan never runs past the last entry in use.
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCMP) |-> (idx_ff <= lim_m1))
      else $error("table scan past last entry");

   // A finished item waits while the previous result is still held.
   a_out_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT) && rsp_valid_ff && !rsp_ready |=> (state_ff == S_OUT))
      else $error("result overwritten before it was taken");

   // Products are only accumulated during the multiply-accumulate passes.
   a_acc_window: assert property (@(posedge clock) disable iff (reset)
      iss_v2_ff |-> (state_ff == S_DR2) || (state_ff == S_DR1) || (state_ff == S_MAC))
      else $error("stray accumulate outside a matrix pass");

endmodule
